// ----- src/assert_macros.svh -----
// assertion helpers for the checker in qs_chk.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define QS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qs check failed");

// next-cycle implication, disabled while rst is high
`define QS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qs check failed");

`endif

// ----- src/qs_pkg.sv -----
// ----------------------------------------------------------------------------
// qs_pkg
// shared constants, controller states and the command/status structs
// ----------------------------------------------------------------------------
package qs_pkg;

  localparam int DEPTH  = 32;
  localparam int IW     = $clog2(DEPTH);
  localparam int CW     = IW + 1;
  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_RD_PIV,
    ST_PIV,
    ST_H_RD,
    ST_H_CMP,
    ST_L_RD,
    ST_L_CMP,
    ST_PLACE,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_POP,
    ST_POP_WAIT,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic rd_lo;
    logic latch_pivot;
    logic rd_hi;
    logic hi_dec;
    logic wr_lo;
    logic lo_inc;
    logic wr_hi;
    logic wr_pivot;
    logic push_a;
    logic push_b;
    logic pop;
    logic pop_load;
    logic emit_rd;
    logic emit_adv;
  } cmd_t;

  typedef struct packed {
    logic cnt_lt2;
    logic lo_lt_hi;
    logic ge_pivot;
    logic le_pivot;
    logic stack_empty;
    logic last_emit;
  } status_t;

endpackage

// ----- src/qs_ctrl.sv -----
// ----------------------------------------------------------------------------
// qs_ctrl
// sequencer for load, partition passes, stack handling and emit
// ----------------------------------------------------------------------------
module qs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             last,
  input  qs_pkg::status_t  sts,
  output qs_pkg::cmd_t     cmd,
  output logic             busy,
  output logic             res_valid
);
  import qs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD:     if (start && last) state_next = ST_INIT;
      ST_INIT:     state_next = sts.cnt_lt2 ? ST_EMIT_RD : ST_RD_PIV;
      ST_RD_PIV:   state_next = ST_PIV;
      ST_PIV:      state_next = ST_H_RD;
      ST_H_RD:     state_next = sts.lo_lt_hi ? ST_H_CMP : ST_PLACE;
      ST_H_CMP:    state_next = sts.ge_pivot ? ST_H_RD : ST_L_RD;
      ST_L_RD:     state_next = sts.lo_lt_hi ? ST_L_CMP : ST_PLACE;
      ST_L_CMP:    state_next = sts.le_pivot ? ST_L_RD : ST_H_RD;
      ST_PLACE:    state_next = ST_PUSH_A;
      ST_PUSH_A:   state_next = ST_PUSH_B;
      ST_PUSH_B:   state_next = ST_POP;
      ST_POP:      state_next = sts.stack_empty ? ST_EMIT_RD : ST_POP_WAIT;
      ST_POP_WAIT: state_next = ST_RD_PIV;
      ST_EMIT_RD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: state_next = sts.last_emit ? ST_LOAD : ST_EMIT_RD;
      default:     state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    res_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INIT:     cmd.init = 1'b1;
      ST_RD_PIV:   cmd.rd_lo = 1'b1;
      ST_PIV:      cmd.latch_pivot = 1'b1;
      ST_H_RD:     cmd.rd_hi = sts.lo_lt_hi;
      ST_H_CMP: begin
        cmd.hi_dec = sts.ge_pivot;
        cmd.wr_lo  = !sts.ge_pivot;
      end
      ST_L_RD:     cmd.rd_lo = sts.lo_lt_hi;
      ST_L_CMP: begin
        cmd.lo_inc = sts.le_pivot;
        cmd.wr_hi  = !sts.le_pivot;
      end
      ST_PLACE:    cmd.wr_pivot = 1'b1;
      ST_PUSH_A:   cmd.push_a = 1'b1;
      ST_PUSH_B:   cmd.push_b = 1'b1;
      ST_POP:      cmd.pop = !sts.stack_empty;
      ST_POP_WAIT: cmd.pop_load = 1'b1;
      ST_EMIT_RD:  cmd.emit_rd = 1'b1;
      ST_EMIT_OUT: begin
        cmd.emit_adv = 1'b1;
        res_valid    = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- src/qs_dp.sv -----
// ----------------------------------------------------------------------------
// qs_dp
// element store, bound stack, range pointers and compare logic
// ----------------------------------------------------------------------------
module qs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  qs_pkg::cmd_t                      cmd,
  input  logic signed [qs_pkg::DATA_W-1:0]  value,
  output qs_pkg::status_t                   sts,
  output logic signed [qs_pkg::DATA_W-1:0]  rdata
);
  import qs_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic [2*IW-1:0]          stk [DEPTH];
  logic [2*IW-1:0]          stk_q;

  logic [CW-1:0]            cnt;
  logic [CW-1:0]            sp;
  logic [IW-1:0]            lo, hi, rlo, rhi, idx;
  logic signed [DATA_W-1:0] pivot;

  logic [CW-1:0]            cnt_m1, sp_m1;
  logic                     rd_en, wr_en, push_ok_a, push_ok_b;
  logic [IW-1:0]            rd_addr, wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  assign cnt_m1    = cnt - 1'b1;
  assign sp_m1     = sp - 1'b1;
  assign push_ok_a = {1'b0, lo} > ({1'b0, rlo} + 1'b1);
  assign push_ok_b = ({1'b0, lo} + 1'b1) < {1'b0, rhi};

  // read port select
  always_comb begin
    rd_en   = cmd.rd_lo | cmd.rd_hi | cmd.emit_rd;
    rd_addr = lo;
    if (cmd.rd_hi) rd_addr = hi;
    else if (cmd.emit_rd) rd_addr = idx;
  end

  // write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lo;
    wr_data = rdata;
    if (cmd.load) begin
      wr_en   = (cnt < CW'(DEPTH));
      wr_addr = cnt[IW-1:0];
      wr_data = value;
    end else if (cmd.wr_lo) begin
      wr_en = 1'b1;
    end else if (cmd.wr_hi) begin
      wr_en   = 1'b1;
      wr_addr = hi;
    end else if (cmd.wr_pivot) begin
      wr_en   = 1'b1;
      wr_data = pivot;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_a && push_ok_a) stk[sp[IW-1:0]] <= {rlo, lo - 1'b1};
    if (cmd.push_b && push_ok_b) stk[sp[IW-1:0]] <= {lo + 1'b1, rhi};
    if (cmd.pop) stk_q <= stk[sp_m1[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_pivot) pivot <= rdata;
    if (cmd.init) begin
      lo  <= '0;
      hi  <= cnt_m1[IW-1:0];
      rlo <= '0;
      rhi <= cnt_m1[IW-1:0];
    end else if (cmd.pop_load) begin
      lo  <= stk_q[2*IW-1:IW];
      rlo <= stk_q[2*IW-1:IW];
      hi  <= stk_q[IW-1:0];
      rhi <= stk_q[IW-1:0];
    end else begin
      if (cmd.hi_dec) hi <= hi - 1'b1;
      if (cmd.lo_inc) lo <= lo + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      sp  <= '0;
      idx <= '0;
    end else begin
      if (cmd.load && cnt < CW'(DEPTH)) cnt <= cnt + 1'b1;
      if (cmd.init) begin
        sp  <= '0;
        idx <= '0;
      end
      if ((cmd.push_a && push_ok_a) || (cmd.push_b && push_ok_b)) sp <= sp + 1'b1;
      if (cmd.pop) sp <= sp_m1;
      if (cmd.emit_adv) begin
        idx <= idx + 1'b1;
        if (sts.last_emit) cnt <= '0;
      end
    end
  end

  always_comb begin
    sts.cnt_lt2     = (cnt < CW'(2));
    sts.lo_lt_hi    = (lo < hi);
    sts.ge_pivot    = (rdata >= pivot);
    sts.le_pivot    = (rdata <= pivot);
    sts.stack_empty = (sp == '0);
    sts.last_emit   = ({1'b0, idx} == cnt_m1);
  end

endmodule

// ----- src/iterative_quicksort.sv -----
// ----------------------------------------------------------------------------
// iterative_quicksort
// collects up to DEPTH signed values, sorts them with quicksort, streams out
// ----------------------------------------------------------------------------
// usage:
//   - a transaction is taken at a clock edge with start high and busy low;
//     value is stored, last closes the set (extra values past DEPTH are
//     dropped, a last that comes while full still starts the sort)
//   - loading accepts one transaction per cycle and busy stays low throughout
//   - after last, busy rises; partition passes walk the element store, which
//     has one read port and one write port; each compare step is a read
//     state followed by a compare state
//   - pending ranges live on a bound stack of (low, high) pairs; each pass
//     adds overhead states for pivot read, pivot latch, place, two pushes,
//     pop and reload
//   - results come out on sorted_value with res_valid high for one cycle,
//     each after a store read; final_res marks the last one, then busy drops
//   - the receiver cannot stall, so each result must be taken on its strobe
//   - rst (synchronous) returns the block to loading with an empty set; the
//     store and stack contents are left as they were
// ----------------------------------------------------------------------------
module iterative_quicksort (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [qs_pkg::DATA_W-1:0]  value,
  input  logic                              last,
  output logic                              res_valid,
  output logic signed [qs_pkg::DATA_W-1:0]  sorted_value,
  output logic                              final_res
);
  import qs_pkg::*;

  cmd_t                     cmd;
  status_t                  sts;
  logic signed [DATA_W-1:0] rdata;
  logic                     strobe;

  // sequencer
  qs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last      (last),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .res_valid (strobe)
  );

  // storage and compare datapath
  qs_dp u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .value (value),
    .sts   (sts),
    .rdata (rdata)
  );

  // result ports, final flag gated by the strobe
  assign res_valid    = strobe;
  assign sorted_value = rdata;
  assign final_res    = strobe & sts.last_emit;

endmodule

// ----- src/qs_chk.sv -----
// ----------------------------------------------------------------------------
// qs_chk
// port-level checks for iterative_quicksort
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qs_chk (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic res_valid,
  input logic final_res
);

  `QS_ASSERT_NOW(a_res_busy, res_valid, busy)
  `QS_ASSERT_NOW(a_final_valid, final_res, res_valid)
  `QS_ASSERT_NXT(a_final_idle, res_valid && final_res, !busy)
  `QS_ASSERT_NXT(a_load_idle, start && !busy && !last, !busy && !res_valid)
  `QS_ASSERT_NXT(a_last_busy, start && !busy && last, busy && !res_valid)

endmodule

bind iterative_quicksort qs_chk u_qs_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last      (last),
  .res_valid (res_valid),
  .final_res (final_res)
);

// ----- sim/iterative_quicksort_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_quicksort_test
// loads sets of signed values, checks the streamed sorted output of each set
// against an in-bench sorted copy, with random gaps on the command side
// ----------------------------------------------------------------------------
module iterative_quicksort_test;
  import qs_pkg::*;

  typedef logic signed [DATA_W-1:0] elem_t;

  typedef struct packed {
    elem_t sorted_value;
    logic  final_res;
  } sorted_out_t;

  // directed row: typed rows carry their own expected result (single-value sets)
  typedef struct {
    elem_t value;
    logic  last;
    logic  typed;
  } dir_row_t;

  localparam elem_t VMIN = 32'sh8000_0000;
  localparam elem_t VMAX = 32'sh7fff_ffff;

  logic  clk;
  logic  rst;
  logic  start;
  logic  busy;
  elem_t value;
  logic  last;
  logic  res_valid;
  elem_t sorted_value;
  logic  final_res;

  iterative_quicksort u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .value(value),
    .last(last), .res_valid(res_valid), .sorted_value(sorted_value),
    .final_res(final_res)
  );

  // collected set for the current load and the sorted results still due
  elem_t       pending_set[$];
  sorted_out_t sorted_due[$];
  int          mismatches;
  logic        gaps_on;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // predict on acceptance: store if room, on last sort the set and queue it out
  task automatic predict_sort(input elem_t v, input logic l);
    elem_t tmp;
    int    j;
    if (pending_set.size() < DEPTH) pending_set.push_back(v);
    if (l) begin
      // insertion sort, ascending signed order
      for (int i = 1; i < pending_set.size(); i++) begin
        tmp = pending_set[i];
        j = i - 1;
        while (j >= 0 && pending_set[j] > tmp) begin
          pending_set[j+1] = pending_set[j];
          j--;
        end
        pending_set[j+1] = tmp;
      end
      foreach (pending_set[i])
        sorted_due.push_back('{pending_set[i], i == pending_set.size() - 1});
      pending_set.delete();
    end
  endtask

  // one command transaction, with optional random idle cycles before it;
  // start stays high after acceptance until the next call or the end
  task automatic send_value(input elem_t v, input logic l);
    while (gaps_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      value <= $urandom;
      last  <= $urandom_range(1);
      @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    last  <= l;
    do @(posedge clk); while (busy);
  endtask

  // result checker: every strobe must match the oldest expected result
  always @(posedge clk) begin
    if (!rst && res_valid) begin
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d final %0b", sorted_value, final_res);
      end else begin
        if (sorted_due[0].sorted_value !== sorted_value ||
            sorted_due[0].final_res !== final_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %0d final %0b, got value %0d final %0b",
                     sorted_due[0].sorted_value, sorted_due[0].final_res,
                     sorted_value, final_res);
        end
        void'(sorted_due.pop_front());
      end
    end
  end

  // random element: full range, narrow range for duplicates, or an extreme
  function automatic elem_t rand_elem();
    case ($urandom_range(3))
      0: rand_elem = $urandom_range(7) - 3;
      1: rand_elem = $urandom_range(1) ? VMIN : VMAX;
      default: rand_elem = $urandom;
    endcase
  endfunction

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_rows[$];
    int       sent;
    int       set_len;
    int       wait_cycles;
    elem_t    v;
    mismatches = 0;
    gaps_on    = 1'b1;
    start      = 1'b0;
    value      = '0;
    last       = 1'b0;
    rst        = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // single-value sets at the extremes and zero, then small sets with the odd cases
    dir_rows = '{
      '{VMIN, 1'b1, 1'b1}, '{VMAX, 1'b1, 1'b1}, '{32'sd0, 1'b1, 1'b1},
      '{32'sd5, 1'b0, 1'b0}, '{VMAX, 1'b0, 1'b0}, '{VMIN, 1'b1, 1'b0},
      '{32'sd7, 1'b0, 1'b0}, '{32'sd7, 1'b0, 1'b0}, '{32'sd7, 1'b1, 1'b0},
      '{32'sd1, 1'b0, 1'b0}, '{32'sd2, 1'b0, 1'b0}, '{32'sd3, 1'b0, 1'b0},
      '{32'sd4, 1'b1, 1'b0},
      '{32'sd4, 1'b0, 1'b0}, '{32'sd3, 1'b0, 1'b0}, '{32'sd2, 1'b0, 1'b0},
      '{-32'sd1, 1'b0, 1'b0}, '{32'sd0, 1'b1, 1'b0},
      '{-32'sd1, 1'b0, 1'b0}, '{32'sd1, 1'b1, 1'b0}
    };
    foreach (dir_rows[i]) begin
      send_value(dir_rows[i].value, dir_rows[i].last);
      if (dir_rows[i].typed) sorted_due.push_back('{dir_rows[i].value, 1'b1});
      else predict_sort(dir_rows[i].value, dir_rows[i].last);
    end

    // random sets, mostly short; some fill the store and overflow it
    sent = 0;
    while (sent < 80) begin
      gaps_on = !(sent >= 30 && sent < 55);
      case ($urandom_range(5))
        0: set_len = DEPTH + $urandom_range(4);   // last may land on a full store
        1: set_len = DEPTH;
        default: set_len = $urandom_range(10, 1);
      endcase
      for (int k = 0; k < set_len; k++) begin
        v = rand_elem();
        send_value(v, k == set_len - 1);
        predict_sort(v, k == set_len - 1);
        sent++;
      end
    end
    start   <= 1'b0;
    gaps_on = 1'b1;

    // drain: wait for every sorted value, then let the clock run on before the verdict
    wait_cycles = 0;
    while (sorted_due.size() != 0 && wait_cycles < 200_000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (64) @(posedge clk);
    if (mismatches == 0 && sorted_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
